FILE: src/dda_pkg.sv
// Package for the DDA line rasterizer: default coordinate width and opcodes.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package dda_pkg;

   // Default width of one coordinate.
   localparam int COORD_BITS = 12;

   // Request opcodes.
   typedef enum logic {
      OP_START = 1'b0,
      OP_NEXT  = 1'b1
   } opcode_type;

endpackage

FILE: src/dda_if.sv
// Handshake interfaces for the request and response channels of the rasterizer.
// Depends on dda_pkg for the default coordinate width and the opcode type.
`timescale 1ns / 1ps

interface dda_req_if #(
   parameter int COORD_BITS = dda_pkg::COORD_BITS
);
   logic                   valid;
   logic                   ready;
   dda_pkg::opcode_type    opcode;
   logic [COORD_BITS-1:0]  start_x;
   logic [COORD_BITS-1:0]  start_y;
   logic [COORD_BITS-1:0]  end_x;
   logic [COORD_BITS-1:0]  end_y;

   modport source (output valid, opcode, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, opcode, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dda_rsp_if #(
   parameter int COORD_BITS = dda_pkg::COORD_BITS
);
   logic                   valid;
   logic                   ready;
   logic [COORD_BITS-1:0]  pixel_x;
   logic [COORD_BITS-1:0]  pixel_y;
   logic                   last_pixel;

   modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
   modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

FILE: src/dda_core.sv
// Line state and one-step DDA logic: segment setup on start, accumulator step on next.
// Depends on dda_pkg for the opcode type.
`timescale 1ns / 1ps

module dda_core #(
   parameter int COORD_BITS = dda_pkg::COORD_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  dda_pkg::opcode_type    opcode,
   input  logic [COORD_BITS-1:0]  start_x,
   input  logic [COORD_BITS-1:0]  start_y,
   input  logic [COORD_BITS-1:0]  end_x,
   input  logic [COORD_BITS-1:0]  end_y,
   output logic                   pixel_emit,
   output logic [COORD_BITS-1:0]  pixel_x,
   output logic [COORD_BITS-1:0]  pixel_y,
   output logic                   last_pixel
);

   localparam int CB    = COORD_BITS;
   localparam int ACC_W = COORD_BITS + 2;

   // Segment state.
   logic                  active_ff,     active_in;
   logic                  y_major_ff,    y_major_in;
   logic [CB-1:0]         major_pos_ff,  major_pos_in;
   logic [CB-1:0]         minor_pos_ff,  minor_pos_in;
   logic [CB-1:0]         steps_left_ff, steps_left_in;
   logic [CB-1:0]         major_len_ff,  major_len_in;
   logic signed [CB:0]    minor_delta_ff, minor_delta_in;
   logic [CB-1:0]         acc_ff,        acc_in;

   // Setup terms.
   logic signed [CB:0]    dx, dy, neg_dx, neg_dy;
   logic [CB-1:0]         adx, ady;
   logic                  set_y_major;
   logic [CB-1:0]         ma0, mi0, ma1, mi1;
   logic                  swap;
   logic [CB-1:0]         s_ma0, s_mi0, s_ma1, s_mi1;

   // Step terms.
   logic signed [ACC_W-1:0] acc_ext, delta_ext, len_ext, acc_sum;

   // Endpoint differences and their magnitudes.
   always_comb begin
      dx     = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
      dy     = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
      neg_dx = -dx;
      neg_dy = -dy;
      adx    = dx[CB] ? neg_dx[CB-1:0] : dx[CB-1:0];
      ady    = dy[CB] ? neg_dy[CB-1:0] : dy[CB-1:0];
      set_y_major = ady > adx;
   end

   // Pick major and minor axes, then order the endpoints so the major coordinate rises.
   always_comb begin
      if (set_y_major) begin
         ma0 = start_y; mi0 = start_x; ma1 = end_y; mi1 = end_x;
      end else begin
         ma0 = start_x; mi0 = start_y; ma1 = end_x; mi1 = end_y;
      end
      swap  = ma1 < ma0;
      s_ma0 = swap ? ma1 : ma0;
      s_mi0 = swap ? mi1 : mi0;
      s_ma1 = swap ? ma0 : ma1;
      s_mi1 = swap ? mi0 : mi1;
   end

   // Accumulator sum for one major step; it stays within one length of the valid range.
   always_comb begin
      acc_ext   = $signed({2'b00, acc_ff});
      delta_ext = $signed({minor_delta_ff[CB], minor_delta_ff});
      len_ext   = $signed({2'b00, major_len_ff});
      acc_sum   = acc_ext + delta_ext;
   end

   // Next state for the current request.
   always_comb begin
      active_in      = active_ff;
      y_major_in     = y_major_ff;
      major_pos_in   = major_pos_ff;
      minor_pos_in   = minor_pos_ff;
      steps_left_in  = steps_left_ff;
      major_len_in   = major_len_ff;
      minor_delta_in = minor_delta_ff;
      acc_in         = acc_ff;
      pixel_emit     = 1'b0;

      if (step_en) begin
         if (opcode == dda_pkg::OP_START) begin
            y_major_in     = set_y_major;
            major_pos_in   = s_ma0;
            minor_pos_in   = s_mi0;
            major_len_in   = s_ma1 - s_ma0;
            steps_left_in  = s_ma1 - s_ma0;
            minor_delta_in = $signed({1'b0, s_mi1}) - $signed({1'b0, s_mi0});
            acc_in         = '0;
            active_in      = (s_ma1 != s_ma0);
            pixel_emit     = 1'b1;
         end else if (active_ff) begin
            major_pos_in  = major_pos_ff + 1'b1;
            steps_left_in = steps_left_ff - 1'b1;
            active_in     = (steps_left_ff != CB'(1));
            pixel_emit    = 1'b1;
            acc_in        = acc_sum[CB-1:0];
            if (!minor_delta_ff[CB]) begin
               if (acc_sum >= len_ext) begin
                  acc_in       = CB'(acc_sum - len_ext);
                  minor_pos_in = minor_pos_ff + 1'b1;
               end
            end else if (acc_sum[ACC_W-1]) begin
               acc_in       = CB'(acc_sum + len_ext);
               minor_pos_in = minor_pos_ff - 1'b1;
            end
         end
      end
   end

   // The emitted pixel is the position after this step.
   always_comb begin
      pixel_x    = y_major_in ? minor_pos_in : major_pos_in;
      pixel_y    = y_major_in ? major_pos_in : minor_pos_in;
      last_pixel = !active_in;
   end

   // State registers; only the running flag needs reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      y_major_ff     <= y_major_in;
      major_pos_ff   <= major_pos_in;
      minor_pos_ff   <= minor_pos_in;
      steps_left_ff  <= steps_left_in;
      major_len_ff   <= major_len_in;
      minor_delta_ff <= minor_delta_in;
      acc_ff         <= acc_in;
   end

endmodule

FILE: src/dda_line_rasterizer.sv
// Top level of the DDA line rasterizer: request handshake, core, response register.
// Depends on dda_pkg, the dda_req_if / dda_rsp_if interfaces and dda_core.
//
//   Channel   Direction  Carries
//   req_bus   in         opcode, start_x, start_y, end_x, end_y
//   rsp_bus   out        pixel_x, pixel_y, last_pixel
//
// For each accepted request the core updates the line state and the pixel lands
// in the response register at the same edge, so one pixel per cycle while rsp_bus is not stalled.
// A start emits the first pixel; a next while no line is running emits nothing.
// req_bus.ready is high while the response register is empty or being drained.
// Synchronous active-high reset clears the running flag and the response valid.
`timescale 1ns / 1ps

module dda_line_rasterizer #(
   parameter int COORD_BITS = dda_pkg::COORD_BITS
) (
   input logic       clock,
   input logic       reset,
   dda_req_if.sink   req_bus,
   dda_rsp_if.source rsp_bus
);

   logic                   req_fire;
   logic                   pixel_emit;
   logic [COORD_BITS-1:0]  pixel_x, pixel_y;
   logic                   last_pixel;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]  rsp_x_ff, rsp_y_ff;
   logic                   rsp_last_ff;

   // Accept while the response slot is free or being taken this cycle.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;

   dda_core #(
      .COORD_BITS (COORD_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (req_fire),
      .opcode     (req_bus.opcode),
      .start_x    (req_bus.start_x),
      .start_y    (req_bus.start_y),
      .end_x      (req_bus.end_x),
      .end_y      (req_bus.end_y),
      .pixel_emit (pixel_emit),
      .pixel_x    (pixel_x),
      .pixel_y    (pixel_y),
      .last_pixel (last_pixel)
   );

   // Response valid: set by an emitting transfer, cleared when the pixel is taken.
   always_comb begin
      if (req_fire) begin
         rsp_valid_in = pixel_emit;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire && pixel_emit) begin
         rsp_x_ff    <= pixel_x;
         rsp_y_ff    <= pixel_y;
         rsp_last_ff <= last_pixel;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.pixel_x    = rsp_x_ff;
   assign rsp_bus.pixel_y    = rsp_y_ff;
   assign rsp_bus.last_pixel = rsp_last_ff;

endmodule
